// ===== rtl/equal_mass_disc_collision_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the disc collision block
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef EQUAL_MASS_DISC_COLLISION_ASSERT_SVH
`define EQUAL_MASS_DISC_COLLISION_ASSERT_SVH

// same-cycle implication, ignored during reset
`define EQD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("disc collision check failed");

// next-cycle implication, ignored during reset
`define EQD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("disc collision check failed");

// next-cycle implication, also checked through reset
`define EQD_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("disc collision reset check failed");

`endif

// ===== rtl/eqd_pkg.sv =====
// ----------------------------------------------------------------------------
// eqd_pkg
// Shared widths, types and helpers for the disc collision block.
// ----------------------------------------------------------------------------
`default_nettype none

package eqd_pkg;

  localparam int VEL_W  = 16;
  localparam int RAD_W  = 14;
  localparam int QB     = 18;  // quotient bits of the correction divide
  localparam int NUM_W  = 51;
  localparam int DEN_W  = 31;
  localparam int D2_W   = 30;
  localparam logic [RAD_W-1:0] RADIUS_RST = 14'd410;

  typedef struct packed {
    logic signed [VEL_W-1:0] vx1;
    logic signed [VEL_W-1:0] vz1;
    logic signed [VEL_W-1:0] vx2;
    logic signed [VEL_W-1:0] vz2;
    logic                    hit;
    logic                    sgx;
    logic                    sgz;
  } carry_t;

  function automatic logic signed [VEL_W-1:0] sat16(input logic signed [20:0] v);
    logic signed [20:0] hi;
    logic signed [20:0] lo;
    hi = 21'sd32767;
    lo = -21'sd32768;
    if (v > hi) begin
      sat16 = 16'sh7fff;
    end else if (v < lo) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[VEL_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/equal_mass_disc_collision.sv =====
// ----------------------------------------------------------------------------
// equal_mass_disc_collision
// Pipelined elastic collision response for two equal-mass discs in 2D.
// ----------------------------------------------------------------------------
//  channel  | ports                        | flow
//  ---------+------------------------------+------------------------
//  in       | in_valid / in_stall / fields | one disc pair per beat
//  out      | out_valid / out_stall / new_ | one result per beat
//  cfg      | cfg_wr_en / cfg_wr_data      | disc_radius, no read
//
//  One beat per cycle sustained while out_stall is low; the 18-stage
//  restoring divider forms rel*d/d2 (one quotient bit per stage).
//  Reset clears all valid bits and sets disc_radius to 410.
//  Stalls collapse bubbles stage by stage; in_stall only rises when every
//  stage holds a beat and out_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module equal_mass_disc_collision
  import eqd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_wr_en,
  input  wire logic [RAD_W-1:0]        cfg_wr_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [VEL_W-1:0] in_first_x,
  input  wire logic signed [VEL_W-1:0] in_first_z,
  input  wire logic signed [VEL_W-1:0] in_first_vx,
  input  wire logic signed [VEL_W-1:0] in_first_vz,
  input  wire logic                    in_first_shown,
  input  wire logic signed [VEL_W-1:0] in_second_x,
  input  wire logic signed [VEL_W-1:0] in_second_z,
  input  wire logic signed [VEL_W-1:0] in_second_vx,
  input  wire logic signed [VEL_W-1:0] in_second_vz,
  input  wire logic                    in_second_shown,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [VEL_W-1:0]      out_new_first_vx,
  output logic signed [VEL_W-1:0]      out_new_first_vz,
  output logic signed [VEL_W-1:0]      out_new_second_vx,
  output logic signed [VEL_W-1:0]      out_new_second_vz,
  output logic                         out_collided
);

  localparam int NS = 6 + QB;  // s1..s5, divider stages, output

  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dz;
    logic signed [16:0] dvx;
    logic signed [16:0] dvz;
    logic [14:0]        reach;
    logic               both;
    carry_t             c;
  } s1_t;

  typedef struct packed {
    logic signed [33:0] sqx;
    logic signed [33:0] sqz;
    logic signed [33:0] px;
    logic signed [33:0] pz;
    logic [D2_W-1:0]    reach2;
    logic signed [16:0] dx;
    logic signed [16:0] dz;
    logic               both;
    carry_t             c;
  } s2_t;

  typedef struct packed {
    logic [D2_W-1:0] d2;
    logic [32:0]     rel;
    logic [15:0]     adx;
    logic [15:0]     adz;
    carry_t          c;
  } s3_t;

  typedef struct packed {
    logic [48:0]     mx;
    logic [48:0]     mz;
    logic [D2_W-1:0] d2;
    carry_t          c;
  } s4_t;

  typedef struct packed {
    logic [NUM_W-1:0] remx;
    logic [NUM_W-1:0] remz;
    logic [DEN_W-1:0] den;
    logic [QB-1:0]    qx;
    logic [QB-1:0]    qz;
    carry_t           c;
  } div_t;

  logic [RAD_W-1:0] radius_r;
  logic [NS-1:0]    vld_r;
  logic [NS-1:0]    en;

  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  s4_t  s4_r, s4_nxt;
  div_t s5_r, s5_nxt;
  div_t dv_r  [QB];
  div_t dv_nxt[QB];

  logic signed [VEL_W-1:0] o_vx1_r, o_vz1_r, o_vx2_r, o_vz2_r;
  logic                    o_hit_r;

  // stage enables, bubbles collapse
  always_comb begin
    en[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      vld_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        radius_r <= cfg_wr_data;
      end
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // s1: differences
  always_comb begin
    s1_nxt.dx    = 17'(in_second_x) - 17'(in_first_x);
    s1_nxt.dz    = 17'(in_second_z) - 17'(in_first_z);
    s1_nxt.dvx   = 17'(in_first_vx) - 17'(in_second_vx);
    s1_nxt.dvz   = 17'(in_first_vz) - 17'(in_second_vz);
    s1_nxt.reach = {radius_r, 1'b0};
    s1_nxt.both  = in_first_shown && in_second_shown;
    s1_nxt.c.vx1 = in_first_vx;
    s1_nxt.c.vz1 = in_first_vz;
    s1_nxt.c.vx2 = in_second_vx;
    s1_nxt.c.vz2 = in_second_vz;
    s1_nxt.c.hit = 1'b0;
    s1_nxt.c.sgx = 1'b0;
    s1_nxt.c.sgz = 1'b0;
  end

  // s2: squares, dot terms, reach squared
  always_comb begin
    s2_nxt.sqx    = 34'(s1_r.dx) * 34'(s1_r.dx);
    s2_nxt.sqz    = 34'(s1_r.dz) * 34'(s1_r.dz);
    s2_nxt.px     = 34'(s1_r.dvx) * 34'(s1_r.dx);
    s2_nxt.pz     = 34'(s1_r.dvz) * 34'(s1_r.dz);
    s2_nxt.reach2 = D2_W'(s1_r.reach) * D2_W'(s1_r.reach);
    s2_nxt.dx     = s1_r.dx;
    s2_nxt.dz     = s1_r.dz;
    s2_nxt.both   = s1_r.both;
    s2_nxt.c      = s1_r.c;
  end

  // s3: d2, rel, collision test
  logic signed [34:0] d2_s3, rel_s3;
  logic signed [16:0] ndx_s3, ndz_s3;
  always_comb begin
    d2_s3  = 35'(s2_r.sqx) + 35'(s2_r.sqz);
    rel_s3 = 35'(s2_r.px) + 35'(s2_r.pz);
    ndx_s3 = -s2_r.dx;
    ndz_s3 = -s2_r.dz;
    s3_nxt.d2  = d2_s3[D2_W-1:0];
    s3_nxt.rel = rel_s3[32:0];
    s3_nxt.adx = s2_r.dx[16] ? ndx_s3[15:0] : s2_r.dx[15:0];
    s3_nxt.adz = s2_r.dz[16] ? ndz_s3[15:0] : s2_r.dz[15:0];
    s3_nxt.c     = s2_r.c;
    s3_nxt.c.sgx = s2_r.dx[16];
    s3_nxt.c.sgz = s2_r.dz[16];
    s3_nxt.c.hit = s2_r.both && (d2_s3 != '0)
                   && ($unsigned(d2_s3) <= {5'b0, s2_r.reach2})
                   && !rel_s3[34];
  end

  // s4: rel * |d|
  always_comb begin
    s4_nxt.mx = 49'(s3_r.rel) * 49'(s3_r.adx);
    s4_nxt.mz = 49'(s3_r.rel) * 49'(s3_r.adz);
    s4_nxt.d2 = s3_r.d2;
    s4_nxt.c  = s3_r.c;
  end

  // s5: rounding numerator and doubled denominator
  always_comb begin
    s5_nxt.remx = NUM_W'({s4_r.mx, 1'b0}) + NUM_W'(s4_r.d2);
    s5_nxt.remz = NUM_W'({s4_r.mz, 1'b0}) + NUM_W'(s4_r.d2);
    s5_nxt.den  = {s4_r.d2, 1'b0};
    s5_nxt.qx   = '0;
    s5_nxt.qz   = '0;
    s5_nxt.c    = s4_r.c;
  end

  always_ff @(posedge clk) begin
    if (en[0]) s1_r <= s1_nxt;
    if (en[1]) s2_r <= s2_nxt;
    if (en[2]) s3_r <= s3_nxt;
    if (en[3]) s4_r <= s4_nxt;
    if (en[4]) s5_r <= s5_nxt;
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int B = QB - 1 - j;
    div_t             prv;
    logic [NUM_W-1:0] trial;
    logic [NUM_W:0]   difx, difz;

    assign prv   = (j == 0) ? s5_r : dv_r[(j == 0) ? 0 : j-1];
    assign trial = NUM_W'(prv.den) << B;
    assign difx  = {1'b0, prv.remx} - {1'b0, trial};
    assign difz  = {1'b0, prv.remz} - {1'b0, trial};

    always_comb begin
      dv_nxt[j]       = prv;
      dv_nxt[j].qx[B] = !difx[NUM_W];
      dv_nxt[j].qz[B] = !difz[NUM_W];
      if (!difx[NUM_W]) begin
        dv_nxt[j].remx = difx[NUM_W-1:0];
      end
      if (!difz[NUM_W]) begin
        dv_nxt[j].remz = difz[NUM_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[5+j]) begin
        dv_r[j] <= dv_nxt[j];
      end
    end
  end

  // output: apply correction and saturate
  div_t               fin;
  logic signed [19:0] cx, cz;
  assign fin = dv_r[QB-1];
  assign cx  = fin.c.sgx ? -$signed(20'(fin.qx)) : $signed(20'(fin.qx));
  assign cz  = fin.c.sgz ? -$signed(20'(fin.qz)) : $signed(20'(fin.qz));

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      o_hit_r <= fin.c.hit;
      if (fin.c.hit) begin
        o_vx1_r <= sat16(21'(fin.c.vx1) - 21'(cx));
        o_vz1_r <= sat16(21'(fin.c.vz1) - 21'(cz));
        o_vx2_r <= sat16(21'(fin.c.vx2) + 21'(cx));
        o_vz2_r <= sat16(21'(fin.c.vz2) + 21'(cz));
      end else begin
        o_vx1_r <= fin.c.vx1;
        o_vz1_r <= fin.c.vz1;
        o_vx2_r <= fin.c.vx2;
        o_vz2_r <= fin.c.vz2;
      end
    end
  end

  assign out_valid         = vld_r[NS-1];
  assign out_new_first_vx  = o_vx1_r;
  assign out_new_first_vz  = o_vz1_r;
  assign out_new_second_vx = o_vx2_r;
  assign out_new_second_vz = o_vz2_r;
  assign out_collided      = o_hit_r;

endmodule

`default_nettype wire

// ===== rtl/eqd_checker.sv =====
// ----------------------------------------------------------------------------
// eqd_checker
// Port-level checks for the disc collision block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "equal_mass_disc_collision_assert.svh"

module eqd_checker
  import eqd_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic signed [VEL_W-1:0] out_new_first_vx,
  input wire logic                    out_collided
);

  `EQD_ASSERT_RST(a_rst_empty, !rst_n, !out_valid)
  `EQD_ASSERT_NOW(a_no_backpressure, !out_stall, !in_stall)
  `EQD_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_new_first_vx) && $stable(out_collided))
  `EQD_ASSERT_NEXT(a_stall_only_full, in_valid && in_stall, out_valid)

endmodule

bind equal_mass_disc_collision eqd_checker u_eqd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_new_first_vx (out_new_first_vx),
  .out_collided     (out_collided)
);

`default_nettype wire
